// ===== sv/fhcc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the frame header CRC checker.
package fhcc_pkg;

  localparam int HDR_BYTES = 20;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int COUNT_W = 33;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_TYPE_LIMIT = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_VERSION   = 3'd3,
    ST_OVERSIZE  = 3'd4,
    ST_CRC       = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [15:0] frame_version;
    logic [15:0] type_limit;
    logic [31:0] payload_cap;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] msg_type;
    logic [31:0] frame_flags;
    logic [31:0] payload_length;
    status_t     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/frame_header_crc_checker.sv =====
// Top level of the frame header and CRC-32 checker.
//
//  channel | direction | handshake            | fields
//  in      | request   | in_valid / in_stall  | in_byte, in_last
//  out     | result    | out_valid / out_stall| kind, payload_byte, msg_type, frame_flags,
//          |           |                      | payload_length, status, last
//  cfg     | write     | cfg_write            | cfg_index, cfg_data
//
// One request per cycle unless in_stall; each passes the stage register, then the queue.
// A final byte that also carries payload yields two results; the 8-entry result queue
// absorbs them and in_stall rises only when it cannot take two more per request in flight.
// Reset is synchronous: registers go to their defaults, the frame state clears.
// A stalled output holds its result; the input keeps flowing until in_stall rises.
module frame_header_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] msg_type,
  output logic [31:0] frame_flags,
  output logic [31:0] payload_length,
  output logic [2:0]  status,
  output logic        last
);
  import fhcc_pkg::*;

  push_t             push;
  res_t              d0, d1, head;
  logic [QCNT_W-1:0] q_count;

  fhcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_count   (q_count),
    .push      (push),
    .d0        (d0),
    .d1        (d1)
  );

  fhcc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .d0        (d0),
    .d1        (d1),
    .q_count   (q_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind           = head.kind;
  assign payload_byte   = head.payload_byte;
  assign msg_type       = head.msg_type;
  assign frame_flags    = head.frame_flags;
  assign payload_length = head.payload_length;
  assign status         = head.status;
  assign last           = head.last;

endmodule

// ===== sv/fhcc_core.sv =====
// Request register, header capture and checks, CRC and status generation.
module fhcc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  input  logic [fhcc_pkg::QCNT_W-1:0] q_count,
  output fhcc_pkg::push_t           push,
  output fhcc_pkg::res_t            d0,
  output fhcc_pkg::res_t            d1
);
  import fhcc_pkg::*;

  cfg_t cfg;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;

  logic [7:0]         hdr_store [HDR_BYTES];
  logic [COUNT_W-1:0] byte_count;
  logic [31:0]        running_crc;
  status_t            error_code;
  logic               header_valid;

  logic [31:0]        h_magic, h_flags, h_length, h_crc, crc_field;
  logic [15:0]        h_version, h_type;
  logic               in_hdr, hdr_last, hdr_done, emit, accept;
  logic [COUNT_W-1:0] len_end, count_next;
  status_t            chk_err, err_next, st;
  logic               hv_next;
  logic [31:0]        crc_next;
  res_t               res_pay, res_stat;

  // room for two results from the stage register plus two from the next request
  assign in_stall = ({1'b0, q_count} + (s1_valid ? (QCNT_W+1)'(2) : '0))
                    > (QCNT_W+1)'(QDEPTH - 2);
  assign accept = in_valid && !in_stall;

  assign h_magic   = {hdr_store[3], hdr_store[2], hdr_store[1], hdr_store[0]};
  assign h_version = {hdr_store[5], hdr_store[4]};
  assign h_type    = {hdr_store[7], hdr_store[6]};
  assign h_flags   = {hdr_store[11], hdr_store[10], hdr_store[9], hdr_store[8]};
  assign h_length  = {hdr_store[15], hdr_store[14], hdr_store[13], hdr_store[12]};
  assign h_crc     = {hdr_store[19], hdr_store[18], hdr_store[17], hdr_store[16]};

  always_comb begin
    in_hdr   = byte_count < COUNT_W'(HDR_BYTES);
    hdr_last = byte_count == COUNT_W'(HDR_BYTES - 1);
    len_end  = {1'b0, h_length} + COUNT_W'(HDR_BYTES);

    if (h_magic != cfg.frame_magic) begin
      chk_err = ST_MALFORMED;
    end else if (h_version != cfg.frame_version) begin
      chk_err = ST_VERSION;
    end else if (h_type == 16'd0 || h_type >= cfg.type_limit) begin
      chk_err = ST_MALFORMED;
    end else if (h_length > cfg.payload_cap) begin
      chk_err = ST_OVERSIZE;
    end else begin
      chk_err = ST_OK;
    end

    err_next = error_code;
    hv_next  = header_valid;
    emit     = 1'b0;
    crc_next = running_crc;
    if (in_hdr) begin
      if (hdr_last) begin
        err_next = chk_err;
        hv_next  = (chk_err == ST_OK);
      end
    end else if (error_code == ST_OK) begin
      if (byte_count >= len_end) begin
        err_next = ST_MALFORMED;
      end else begin
        emit     = 1'b1;
        crc_next = crc_byte(running_crc, s1_byte);
      end
    end

    count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
    hdr_done   = count_next >= COUNT_W'(HDR_BYTES);
    // last header byte still sits in the stage register
    crc_field  = hdr_last ? {s1_byte, hdr_store[18], hdr_store[17], hdr_store[16]} : h_crc;

    if (!hdr_done) begin
      st = ST_TRUNC;
    end else if (err_next != ST_OK) begin
      st = err_next;
    end else if (!hv_next) begin
      st = ST_MALFORMED;
    end else if (count_next != len_end) begin
      st = ST_MALFORMED;
    end else if ((crc_next ^ CRC_INIT) != crc_field) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end

    res_pay.kind           = KIND_PAYLOAD;
    res_pay.payload_byte   = s1_byte;
    res_pay.msg_type       = h_type;
    res_pay.frame_flags    = h_flags;
    res_pay.payload_length = h_length;
    res_pay.status         = ST_OK;
    res_pay.last           = 1'b0;

    res_stat.kind           = KIND_STATUS;
    res_stat.payload_byte   = 8'd0;
    res_stat.msg_type       = hdr_done ? h_type : 16'd0;
    res_stat.frame_flags    = hdr_done ? h_flags : 32'd0;
    res_stat.payload_length = hdr_done ? h_length : 32'd0;
    res_stat.status         = st;
    res_stat.last           = 1'b1;

    push.first  = s1_valid && (emit || s1_last);
    push.second = s1_valid && emit && s1_last;
    d0 = emit ? res_pay : res_stat;
    d1 = res_stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_magic   <= 32'd0;
      cfg.frame_version <= 16'd1;
      cfg.type_limit    <= 16'd2;
      cfg.payload_cap   <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAGIC:       cfg.frame_magic   <= cfg_data;
        REG_VERSION:     cfg.frame_version <= cfg_data[15:0];
        REG_TYPE_LIMIT:  cfg.type_limit    <= cfg_data[15:0];
        REG_MAX_PAYLOAD: cfg.payload_cap   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && in_hdr) begin
      hdr_store[byte_count[HDR_IDX_W-1:0]] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_crc  <= CRC_INIT;
      error_code   <= ST_OK;
      header_valid <= 1'b0;
    end else if (s1_valid) begin
      if (s1_last) begin
        byte_count   <= '0;
        running_crc  <= CRC_INIT;
        error_code   <= ST_OK;
        header_valid <= 1'b0;
      end else begin
        byte_count   <= count_next;
        running_crc  <= crc_next;
        error_code   <= err_next;
        header_valid <= hv_next;
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |=> byte_count == '0 && error_code == ST_OK)
    else $error("frame state not cleared after last byte");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    push.first && d0.kind == KIND_PAYLOAD |->
      byte_count >= COUNT_W'(HDR_BYTES) && error_code == ST_OK)
    else $error("payload forwarded inside header or after error");

  a_second_is_status: assert property (@(posedge clk) disable iff (rst)
    push.second |-> s1_last && d1.last && d0.kind == KIND_PAYLOAD)
    else $error("second result is not the closing status");

endmodule

// ===== sv/fhcc_out_queue.sv =====
// Result queue taking up to two results per cycle and handing out one while out_stall is low.
module fhcc_out_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  fhcc_pkg::push_t             push,
  input  fhcc_pkg::res_t              d0,
  input  fhcc_pkg::res_t              d1,
  output logic [fhcc_pkg::QCNT_W-1:0] q_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fhcc_pkg::res_t              head
);
  import fhcc_pkg::*;

  res_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_next;
  logic [QCNT_W-1:0] q_count_next;
  logic              pop;

  assign out_valid = q_count != '0;
  assign head      = entry[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_next  = wr_ptr + QPTR_W'(push.first) + QPTR_W'(push.second);
    q_count_next = q_count + QCNT_W'(push.first) + QCNT_W'(push.second) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr_next;
      q_count <= q_count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entry[wr_ptr] <= d0;
    end
    if (push.second) begin
      entry[wr_ptr + QPTR_W'(1)] <= d1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second push without first");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !push.first && !pop |=> $stable(q_count))
    else $error("queue count moved without push or pop");

endmodule

// ===== bench/frame_result_checker.sv =====
// Frame result checker: follows the request, result and register ports, predicts and compares.
`timescale 1ns / 1ps
module frame_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [7:0]  payload_byte,
  input  logic [15:0] msg_type,
  input  logic [31:0] frame_flags,
  input  logic [31:0] payload_length,
  input  logic [2:0]  status,
  input  logic        last,
  output int          mismatches,
  output int          pending,
  output int          results_checked,
  output logic [5:0]  statuses_seen
);
  import fhcc_pkg::*;

  cfg_t regs;
  logic [7:0] hdr [HDR_BYTES];
  logic [COUNT_W-1:0] frame_bytes;
  logic [31:0] payload_crc;
  status_t first_error;
  logic header_ok;
  res_t expected_results [$];
  logic [31:0] crc_table [256];

  initial begin
    logic [31:0] c;
    for (int n = 0; n < 256; n++) begin
      c = n;
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      crc_table[n] = c;
    end
  end

  function automatic logic [31:0] header_le(int off, int count);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < count; i++) v[8*i +: 8] = hdr[off + i];
    return v;
  endfunction

  function automatic res_t frame_item(logic k, logic [7:0] pb, logic decoded, status_t st);
    res_t r;
    r.kind = k;
    r.payload_byte = pb;
    r.msg_type = decoded ? header_le(6, 2) : '0;
    r.frame_flags = decoded ? header_le(8, 4) : '0;
    r.payload_length = decoded ? header_le(12, 4) : '0;
    r.status = st;
    r.last = (k == KIND_STATUS);
    return r;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return 1;
  endfunction

  task automatic clear_frame;
    frame_bytes = '0;
    payload_crc = CRC_INIT;
    first_error = ST_OK;
    header_ok = 1'b0;
  endtask

  task automatic predict_frame_byte(logic [7:0] b, logic fin);
    logic [15:0] mtype;
    status_t st;
    if (frame_bytes < HDR_BYTES) begin
      hdr[frame_bytes] = b;
      if (frame_bytes == HDR_BYTES - 1) begin
        mtype = header_le(6, 2);
        if (header_le(0, 4) != regs.frame_magic) first_error = ST_MALFORMED;
        else if (header_le(4, 2) != regs.frame_version) first_error = ST_VERSION;
        else if (mtype == 0 || mtype >= regs.type_limit) first_error = ST_MALFORMED;
        else if (header_le(12, 4) > regs.payload_cap) first_error = ST_OVERSIZE;
        else header_ok = 1'b1;
      end
    end else if (first_error == ST_OK) begin
      // a byte past the declared length is an error, not payload
      if (frame_bytes - HDR_BYTES >= header_le(12, 4)) begin
        first_error = ST_MALFORMED;
      end else begin
        payload_crc = (payload_crc >> 8) ^ crc_table[payload_crc[7:0] ^ b];
        expected_results.push_back(frame_item(KIND_PAYLOAD, b, 1'b1, ST_OK));
      end
    end
    if (frame_bytes != COUNT_MAX) frame_bytes++;
    if (fin) begin
      if (frame_bytes < HDR_BYTES) st = ST_TRUNC;
      else if (first_error != ST_OK) st = first_error;
      else if (!header_ok) st = ST_MALFORMED;
      else if (frame_bytes != HDR_BYTES + header_le(12, 4)) st = ST_MALFORMED;
      else if (~payload_crc != header_le(16, 4)) st = ST_CRC;
      else st = ST_OK;
      expected_results.push_back(frame_item(KIND_STATUS, 8'd0, frame_bytes >= HDR_BYTES, st));
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs.frame_magic = 32'd0;
      regs.frame_version = 16'd1;
      regs.type_limit = 16'd2;
      regs.payload_cap = 32'd65536;
      for (int i = 0; i < HDR_BYTES; i++) hdr[i] = 8'd0;
      clear_frame();
      expected_results.delete();
      mismatches = 0;
      results_checked = 0;
      statuses_seen = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d", kind, status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          mismatches += field_differs("kind", want.kind, kind)
                      + field_differs("payload_byte", want.payload_byte, payload_byte)
                      + field_differs("msg_type", want.msg_type, msg_type)
                      + field_differs("frame_flags", want.frame_flags, frame_flags)
                      + field_differs("payload_length", want.payload_length, payload_length)
                      + field_differs("status", want.status, status)
                      + field_differs("last", want.last, last);
          results_checked++;
          if (kind == KIND_STATUS) statuses_seen[status] = 1'b1;
        end
      end
      if (in_valid && !in_stall) predict_frame_byte(in_byte, in_last);
      if (cfg_write) begin
        case (cfg_index)
          REG_MAGIC:       regs.frame_magic = cfg_data;
          REG_VERSION:     regs.frame_version = cfg_data[15:0];
          REG_TYPE_LIMIT:  regs.type_limit = cfg_data[15:0];
          REG_MAX_PAYLOAD: regs.payload_cap = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/frame_header_crc_checker_test.sv =====
// Testbench top: drives framed byte requests and register settings, reports the verdict.
`timescale 1ns / 1ps
module frame_header_crc_checker_test;
  import fhcc_pkg::*;

  typedef enum {
    FR_GOOD, FR_BAD_MAGIC, FR_BAD_VERSION, FR_BAD_TYPE, FR_OVERSIZE,
    FR_EXTRA, FR_SHORT, FR_BAD_CRC, FR_CUT, FR_NOISE
  } frame_fault_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_MAGIC;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] msg_type;
  logic [31:0] frame_flags;
  logic [31:0] payload_length;
  logic [2:0]  status;
  logic        last;

  int mismatches;
  int pending;
  int results_checked;
  logic [5:0] statuses_seen;

  bit calm = 1'b0;
  cfg_t setting;
  int frames_sent = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  frame_header_crc_checker uut (.*);
  frame_result_checker frame_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_stall <= !rst && !calm && ($urandom_range(99) < 25);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(REG_MAGIC, s.frame_magic);
    write_reg(REG_VERSION, {16'd0, s.frame_version});
    write_reg(REG_TYPE_LIMIT, {16'd0, s.type_limit});
    write_reg(REG_MAX_PAYLOAD, s.payload_cap);
    cfg_write <= 1'b0;
    setting = s;
    settings_used++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= fin;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_fault_t fault, int plen);
    logic [31:0] magic, flags, len, crc;
    logic [15:0] version, mtype;
    logic [7:0] body [$];
    logic [7:0] buffer [$];
    int n;
    int keep;
    magic = setting.frame_magic;
    version = setting.frame_version;
    flags = $urandom;
    if (setting.type_limit > 1) mtype = 16'($urandom_range(setting.type_limit - 1, 1));
    else mtype = 16'($urandom_range(65535));
    len = (32'(plen) > setting.payload_cap) ? setting.payload_cap : 32'(plen);
    n = len;
    case (fault)
      FR_BAD_MAGIC:   magic ^= 32'd1 << $urandom_range(31);
      FR_BAD_VERSION: version ^= 16'd1 << $urandom_range(15);
      FR_BAD_TYPE:    mtype = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, setting.type_limit));
      FR_OVERSIZE: begin
        if (setting.payload_cap != 32'hFFFF_FFFF) begin
          len = $urandom_range(1) ? 32'hFFFF_FFFF : setting.payload_cap + 1;
          n = $urandom_range(4);
        end
      end
      FR_EXTRA: n = len + $urandom_range(3, 1);
      FR_SHORT: n = (len == 0) ? 1 : $urandom_range(len - 1);
      default: ;
    endcase
    crc = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      body.push_back(8'($urandom));
      if (i < len) begin
        crc ^= {24'd0, body[i]};
        repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    crc = ~crc;
    if (fault == FR_BAD_CRC) crc ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) buffer.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 2; i++) buffer.push_back(version[8*i +: 8]);
    for (int i = 0; i < 2; i++) buffer.push_back(mtype[8*i +: 8]);
    for (int i = 0; i < 4; i++) buffer.push_back(flags[8*i +: 8]);
    for (int i = 0; i < 4; i++) buffer.push_back(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) buffer.push_back(crc[8*i +: 8]);
    foreach (body[i]) buffer.push_back(body[i]);
    if (fault == FR_CUT) begin
      keep = $urandom_range(HDR_BYTES - 1, 1);
      while (buffer.size() > keep) void'(buffer.pop_back());
    end
    if (fault == FR_NOISE) begin
      buffer.delete();
      repeat ($urandom_range(48, 1)) buffer.push_back(8'($urandom));
    end
    foreach (buffer[i]) send_byte(buffer[i], i == buffer.size() - 1);
    frames_sent++;
  endtask

  task automatic random_frames(int budget);
    int start;
    int pick;
    int plen;
    frame_fault_t fault;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 50) fault = FR_GOOD;
      else if (pick < 56) fault = FR_BAD_MAGIC;
      else if (pick < 62) fault = FR_BAD_VERSION;
      else if (pick < 68) fault = FR_BAD_TYPE;
      else if (pick < 74) fault = FR_OVERSIZE;
      else if (pick < 80) fault = FR_EXTRA;
      else if (pick < 86) fault = FR_SHORT;
      else if (pick < 92) fault = FR_BAD_CRC;
      else if (pick < 96) fault = FR_CUT;
      else fault = FR_NOISE;
      plen = ($urandom_range(9) < 8) ? $urandom_range(12) : $urandom_range(48, 13);
      send_frame(fault, plen);
      // occasionally hold requests until every result is back
      if ($urandom_range(19) == 0) drain();
    end
  endtask

  initial begin
    cfg_t s;
    setting = '{32'd0, 16'd1, 16'd2, 32'd65536};
    settings_used = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_frame(FR_CUT, 0);
    send_frame(FR_GOOD, 0);
    send_frame(FR_GOOD, 3);
    send_frame(FR_BAD_MAGIC, 1);
    send_frame(FR_BAD_VERSION, 1);
    send_frame(FR_BAD_TYPE, 1);
    send_frame(FR_BAD_TYPE, 0);
    send_frame(FR_OVERSIZE, 0);
    send_frame(FR_EXTRA, 2);
    send_frame(FR_SHORT, 3);
    send_frame(FR_BAD_CRC, 2);
    send_frame(FR_NOISE, 0);
    drain();

    apply_setting('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
    random_frames(PHASE_BYTES);
    drain();

    // type limit of one leaves no valid type; a payload cap of zero allows only empty payloads
    apply_setting('{32'd0, 16'd0, 16'd1, 32'd0});
    random_frames(PHASE_BYTES);
    drain();

    s.frame_magic = $urandom;
    s.frame_version = 16'($urandom);
    s.type_limit = 16'($urandom_range(300, 2));
    s.payload_cap = $urandom_range(40);
    apply_setting(s);
    calm = 1'b1;
    random_frames(2 * PHASE_BYTES);
    calm = 1'b0;
    drain();

    s.frame_magic = $urandom;
    s.frame_version = 16'($urandom);
    s.type_limit = 16'd0;
    s.payload_cap = 32'd20;
    apply_setting(s);
    random_frames(PHASE_BYTES);
    drain();

    s.frame_magic = $urandom;
    s.frame_version = 16'($urandom);
    s.type_limit = 16'($urandom_range(8, 2));
    s.payload_cap = $urandom_range(64, 8);
    apply_setting(s);
    random_frames(PHASE_BYTES);
    drain();

    $display("Run covered %0d frames, %0d request bytes, %0d register settings, %0d results.",
             frames_sent, bytes_sent, settings_used, results_checked);
    $display("Status codes returned (one bit per code, ok in bit 0): %b", statuses_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
